// ===== src/spmv_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply: shared definitions
// Item codes, register indexes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package spmv_pkg;

  localparam int COL_W   = 12;
  localparam int VAL_W   = 32;
  localparam int ROW_W   = 16;
  localparam int SUM_W   = 48;
  localparam int PROD_W  = 64;
  localparam int NCOL_W  = 13;
  localparam int THR_W   = 16;
  localparam int CFG_W   = 16;
  localparam int EPOCH_W = 8;
  localparam int WORD_W  = EPOCH_W + VAL_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_MATRIX = 2'd2,
    OP_EMPTY  = 2'd3
  } op_t;

  typedef enum logic {
    REG_NUM_COLS = 1'b0,
    REG_ZERO_THR = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_SWEEP = 1'b0,
    ST_RUN   = 1'b1
  } ctl_state_t;

  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

endpackage

// ===== src/spmv_ram.sv =====
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spmv_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sparse_matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply, CSR rows, Q16.16 entries
// Vector entries sit in one RAM tagged with a clear epoch; matrix entries look
// up the vector, multiply, accumulate with saturation and report row sums.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    func, col_index, value, row_end
//  out_     output     out_valid / out_ready  row_index, row_sum
//  cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// One item is taken per cycle; a result reaches the output register once its
// row-ending item has passed the RAM read, multiply, add and test stages.
// A full output register that is not taken stops the whole pipeline.
// After reset, and after every 255th clear, the epoch tags are swept, one RAM
// entry a cycle, and no item is accepted during the sweep.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply #(
  parameter int COLUMNS  = 4096,
  parameter int MAX_ROWS = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_func,
  input  logic [spmv_pkg::COL_W-1:0]         in_col_index,
  input  logic signed [spmv_pkg::VAL_W-1:0]  in_value,
  input  logic                               in_row_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spmv_pkg::ROW_W-1:0]         out_row_index,
  output logic signed [spmv_pkg::SUM_W-1:0]  out_row_sum,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [spmv_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW        = $clog2(COLUMNS);
  localparam int ROW_LIMIT = (MAX_ROWS < 65536) ? MAX_ROWS : 65536;

  localparam int EW = spmv_pkg::EPOCH_W;
  localparam int VW = spmv_pkg::VAL_W;
  localparam int SW = spmv_pkg::SUM_W;
  localparam int PW = spmv_pkg::PROD_W;
  localparam int ROW_W_L = spmv_pkg::ROW_W;

  // Configuration.
  logic [spmv_pkg::NCOL_W-1:0] num_cols_r;
  logic [spmv_pkg::THR_W-1:0]  zero_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= spmv_pkg::NCOL_W'(4096);
      zero_thr_r <= spmv_pkg::THR_W'(1);
    end else if (cfg_we) begin
      case (spmv_pkg::reg_idx_t'(cfg_index))
        spmv_pkg::REG_NUM_COLS: num_cols_r <= cfg_wdata[spmv_pkg::NCOL_W-1:0];
        spmv_pkg::REG_ZERO_THR: zero_thr_r <= cfg_wdata[spmv_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state.
  spmv_pkg::ctl_state_t state_r, state_nxt;
  logic [AW-1:0]        sweep_addr_r, sweep_addr_nxt;
  logic [EW-1:0]        epoch_r, epoch_nxt;

  logic         adv;
  logic         accept;
  spmv_pkg::op_t in_op;
  logic         in_inrng;
  logic         in_err;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [spmv_pkg::WORD_W-1:0]    ram_wdata;
  logic                           ram_re;
  logic [spmv_pkg::WORD_W-1:0]    ram_rdata;

  assign in_op    = spmv_pkg::op_t'(in_func);
  assign in_inrng = 17'(in_col_index) < 17'(COLUMNS);
  assign in_err   = {1'b0, in_col_index} >= num_cols_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    sweep_addr_nxt = sweep_addr_r;
    epoch_nxt      = epoch_r;
    case (state_r)
      spmv_pkg::ST_SWEEP: begin
        sweep_addr_nxt = sweep_addr_r + AW'(1);
        epoch_nxt      = spmv_pkg::EPOCH_FIRST;
        if (sweep_addr_r == AW'(COLUMNS - 1)) begin
          state_nxt = spmv_pkg::ST_RUN;
        end
      end
      spmv_pkg::ST_RUN: begin
        if (accept && in_op == spmv_pkg::OP_CLEAR) begin
          if (epoch_r == spmv_pkg::EPOCH_LAST) begin
            state_nxt      = spmv_pkg::ST_SWEEP;
            sweep_addr_nxt = '0;
          end else begin
            epoch_nxt = epoch_r + EW'(1);
          end
        end
      end
      default: state_nxt = spmv_pkg::ST_SWEEP;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(in_col_index);
    ram_wdata = {epoch_r, in_value};
    ram_re    = 1'b0;
    case (state_r)
      spmv_pkg::ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr_r;
        ram_wdata = '0;
      end
      spmv_pkg::ST_RUN: begin
        in_ready = adv;
        ram_we   = accept && in_op == spmv_pkg::OP_LOAD && in_inrng;
        ram_re   = accept && in_op == spmv_pkg::OP_MATRIX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spmv_pkg::ST_SWEEP;
      sweep_addr_r <= '0;
      epoch_r      <= spmv_pkg::EPOCH_FIRST;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      epoch_r      <= epoch_nxt;
    end
  end

  spmv_ram #(
    .WIDTH (spmv_pkg::WORD_W),
    .DEPTH (COLUMNS)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(in_col_index)),
    .rdata (ram_rdata)
  );

  // Stage 1: vector lookup and multiply.
  logic                 s1_vld_r;
  spmv_pkg::op_t        s1_op_r;
  logic signed [VW-1:0] s1_val_r;
  logic                 s1_last_r;
  logic                 s1_inrng_r;
  logic                 s1_err_r;
  logic                 s1_hit;
  logic signed [VW-1:0] mul_b;
  logic signed [PW-1:0] prod_nxt;

  assign s1_hit   = s1_op_r == spmv_pkg::OP_MATRIX && s1_inrng_r &&
                    ram_rdata[spmv_pkg::WORD_W-1:VW] == epoch_r;
  assign mul_b    = s1_hit ? signed'(ram_rdata[VW-1:0]) : '0;
  assign prod_nxt = s1_val_r * mul_b;

  // Stage 2: saturating accumulate.
  logic                 s2_vld_r;
  spmv_pkg::op_t        s2_op_r;
  logic signed [PW-1:0] s2_prod_r;
  logic                 s2_end_r;
  logic                 s2_err_r;
  logic signed [SW-1:0] acc_r, acc_nxt;
  logic signed [SW-1:0] prod_sh;
  logic signed [SW:0]   sum_w;
  logic signed [SW-1:0] sum_sat;

  assign prod_sh = s2_prod_r[PW-1:16];
  assign sum_w   = {acc_r[SW-1], acc_r} + {prod_sh[SW-1], prod_sh};

  always_comb begin
    sum_sat = sum_w[SW-1:0];
    if (sum_w[SW] != sum_w[SW-1]) begin
      sum_sat = sum_w[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (adv && s2_vld_r) begin
      case (s2_op_r)
        spmv_pkg::OP_CLEAR:  acc_nxt = '0;
        spmv_pkg::OP_MATRIX,
        spmv_pkg::OP_EMPTY:  acc_nxt = s2_end_r ? '0 : sum_sat;
        default: ;
      endcase
    end
  end

  // Stage 3: threshold test and row count.
  logic                 s3_vld_r;
  spmv_pkg::op_t        s3_op_r;
  logic signed [SW-1:0] s3_sum_r;
  logic                 s3_end_r;
  logic                 s3_err_r;
  logic [ROW_W_L-1:0]   row_cnt_r, row_cnt_nxt;
  logic                 range_err_r, range_err_nxt;
  logic [SW-1:0]        mag;
  logic                 emit;
  logic [ROW_W_L:0]     row_inc;

  assign mag     = s3_sum_r[SW-1] ? (~s3_sum_r + SW'(1)) : s3_sum_r;
  assign emit    = s3_vld_r && s3_end_r && !range_err_r &&
                   mag >= SW'(zero_thr_r);
  assign row_inc = {1'b0, row_cnt_r} + (ROW_W_L + 1)'(1);

  always_comb begin
    row_cnt_nxt   = row_cnt_r;
    range_err_nxt = range_err_r;
    if (adv && s3_vld_r) begin
      case (s3_op_r)
        spmv_pkg::OP_CLEAR: begin
          row_cnt_nxt   = '0;
          range_err_nxt = 1'b0;
        end
        spmv_pkg::OP_LOAD: begin
          if (s3_err_r) begin
            range_err_nxt = 1'b1;
          end
        end
        spmv_pkg::OP_MATRIX,
        spmv_pkg::OP_EMPTY: begin
          if (s3_end_r) begin
            row_cnt_nxt = (row_inc == (ROW_W_L + 1)'(ROW_LIMIT)) ?
                          '0 : row_inc[ROW_W_L-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  logic                    out_valid_r;
  logic [ROW_W_L-1:0]      out_row_index_r;
  logic signed [SW-1:0]    out_row_sum_r;

  assign adv           = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_index_r;
  assign out_row_sum   = out_row_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      row_cnt_r   <= '0;
      range_err_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      row_cnt_r   <= row_cnt_nxt;
      range_err_r <= range_err_nxt;
      if (adv) begin
        s1_vld_r    <= accept;
        s2_vld_r    <= s1_vld_r;
        s3_vld_r    <= s2_vld_r;
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= in_op;
      s1_val_r   <= in_value;
      s1_last_r  <= in_row_end;
      s1_inrng_r <= in_inrng;
      s1_err_r   <= in_err;

      s2_op_r   <= s1_op_r;
      s2_prod_r <= prod_nxt;
      s2_end_r  <= s1_op_r == spmv_pkg::OP_EMPTY ||
                   (s1_op_r == spmv_pkg::OP_MATRIX && s1_last_r);
      s2_err_r  <= s1_err_r;

      s3_op_r  <= s2_op_r;
      s3_sum_r <= sum_sat;
      s3_end_r <= s2_end_r;
      s3_err_r <= s2_err_r;

      if (emit) begin
        out_row_index_r <= row_cnt_r;
        out_row_sum_r   <= s3_sum_r;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_beat_in_sweep : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spmv_pkg::ST_SWEEP |-> !in_ready && !ram_re)
    else $error("input beat or vector read during the tag sweep");

  a_epoch_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spmv_pkg::ST_RUN |-> epoch_r != '0)
    else $error("live epoch equals the swept tag value");

  a_result_from_row_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(s3_vld_r && s3_end_r))
    else $error("result without a row-ending item");

  a_clear_empties_acc : assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_vld_r && s2_op_r == spmv_pkg::OP_CLEAR |=> acc_r == '0)
    else $error("accumulator not emptied by a clear");
`endif

endmodule
